// ===== rtl/core/glbm_pkg.sv =====
package glbm_pkg;

   localparam logic [1:0] CmdPatternByte = 2'd0;
   localparam logic [1:0] CmdPatternEnd  = 2'd1;
   localparam logic [1:0] CmdSubjectByte = 2'd2;
   localparam logic [1:0] CmdSubjectEnd  = 2'd3;

   localparam logic [7:0] StarByte     = 8'h2A;
   localparam logic [7:0] QuestionByte = 8'h3F;

   typedef enum logic [1:0] {
      OP_PATTERN_BYTE,
      OP_PATTERN_END,
      OP_SUBJECT_BYTE,
      OP_SUBJECT_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] folded;
   } item_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } result_type;

endpackage

// ===== rtl/core/glob_wildcard_matcher_unit.sv =====
// Case-insensitive glob matcher with '*' and '?' wildcards.
// Input transactions are pushed with req_push while req_full is low. Each
// carries req_command and req_char_byte: pattern bytes, end of pattern,
// subject bytes, and end of subject. Only end of subject produces a result
// transaction, which holds rsp_matched and rsp_pattern_overflow.
// Results wait in a two-entry queue; the oldest is on the rsp_ ports while
// rsp_empty is low and is removed by rsp_pop.
// The block accepts one transaction per cycle while req_full is low. Items
// pass through a two-entry queue into the matcher, which updates every
// pattern position of its prefix vector combinationally. An end-of-subject
// item is registered in the input queue, and its result is registered in
// the result queue before it appears on the rsp_ ports.
// When the receiver stalls and the result queue fills, the matcher holds
// at the next end-of-subject item and the input queue then raises req_full.
// Reset empties both queues, clears the stored pattern length and the
// overflow flag, and puts the block into pattern loading.
module glob_wildcard_matcher_unit #(
   parameter int MAX_PATTERN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_command,
   input  logic [7:0] req_char_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow
);

   localparam int ItemW   = $bits(glbm_pkg::item_type);
   localparam int ResultW = $bits(glbm_pkg::result_type);

   glbm_pkg::item_type   front_item, eng_item;
   glbm_pkg::result_type eng_result, rsp_result;
   logic [ItemW-1:0]     eng_item_bits;
   logic [ResultW-1:0]   rsp_result_bits;
   logic                 eng_empty, eng_pop, res_full, res_push;

   glbm_front u_front (
      .command   (req_command),
      .char_byte (req_char_byte),
      .item      (front_item)
   );

   glbm_queue #(.W(ItemW)) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_item),
      .full  (req_full),
      .pop   (eng_pop),
      .rdata (eng_item_bits),
      .empty (eng_empty)
   );

   assign eng_item = glbm_pkg::item_type'(eng_item_bits);

   glbm_engine #(.MAX_PATTERN(MAX_PATTERN)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .in_empty   (eng_empty),
      .in_item    (eng_item),
      .in_pop     (eng_pop),
      .out_full   (res_full),
      .out_push   (res_push),
      .out_result (eng_result)
   );

   glbm_queue #(.W(ResultW)) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (eng_result),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (rsp_result_bits),
      .empty (rsp_empty)
   );

   assign rsp_result           = glbm_pkg::result_type'(rsp_result_bits);
   assign rsp_matched          = rsp_result.matched;
   assign rsp_pattern_overflow = rsp_result.pattern_overflow;

endmodule

// ===== rtl/core/glbm_front.sv =====
module glbm_front (
   input  logic [1:0]        command,
   input  logic [7:0]        char_byte,
   output glbm_pkg::item_type item
);

   always_comb begin
      item.folded = char_byte;
      if (char_byte >= 8'h41 && char_byte <= 8'h5A) begin
         item.folded = char_byte + 8'h20;
      end
      case (command)
         glbm_pkg::CmdPatternByte: item.op = glbm_pkg::OP_PATTERN_BYTE;
         glbm_pkg::CmdPatternEnd:  item.op = glbm_pkg::OP_PATTERN_END;
         glbm_pkg::CmdSubjectByte: item.op = glbm_pkg::OP_SUBJECT_BYTE;
         default:                  item.op = glbm_pkg::OP_SUBJECT_END;
      endcase
   end

endmodule

// ===== rtl/core/glbm_queue.sv =====
module glbm_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wdata,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] rdata,
   output logic         empty
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/core/glbm_engine.sv =====
module glbm_engine #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_empty,
   input  glbm_pkg::item_type   in_item,
   output logic                 in_pop,
   input  logic                 out_full,
   output logic                 out_push,
   output glbm_pkg::result_type out_result
);

   localparam int N    = MAX_PATTERN + 1;
   localparam int LenW = $clog2(MAX_PATTERN + 1);
   localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [7:0]            pat_ff [MAX_PATTERN];
   logic [LenW-1:0]       len_ff, len_in;
   logic [N-1:0]          active_ff, active_in;
   logic [N-1:0]          lead_ff, lead_in;
   logic                  ovf_ff, ovf_in;
   logic                  loading_ff, loading_in;

   logic [MAX_PATTERN-1:0] in_range, is_star, is_any, is_eq;
   logic [MAX_PATTERN-1:0] stay, adv;
   logic [N-1:0]           base, next_raw, lead_base, prop, add_a;
   logic [N:0]             sum, carries;
   logic [N-1:0]           closed;
   logic                   start, has_room, pat_we;
   logic [IdxW-1:0]        pat_idx;
   logic [LenW-1:0]        lead_idx;

   assign in_pop = !in_empty &&
                   !(in_item.op == glbm_pkg::OP_SUBJECT_END && out_full);

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         in_range[i] = LenW'(i) < len_ff;
         is_star[i]  = in_range[i] && (pat_ff[i] == glbm_pkg::StarByte);
         is_any[i]   = pat_ff[i] == glbm_pkg::QuestionByte;
         is_eq[i]    = pat_ff[i] == in_item.folded;
      end
   end

   // Star closure as a carry chain: each star passes a live prefix upward.
   always_comb begin
      base     = loading_ff ? lead_ff : active_ff;
      stay     = base[MAX_PATTERN-1:0] & is_star;
      adv      = base[MAX_PATTERN-1:0] & in_range & ~is_star & (is_any | is_eq);
      next_raw = {1'b0, stay} | {adv, 1'b0};
      prop     = {is_star, 1'b0} & ~next_raw;
      add_a    = next_raw | prop;
      sum      = {1'b0, add_a} + {1'b0, next_raw};
      carries  = sum ^ {1'b0, add_a} ^ {1'b0, next_raw};
      closed   = carries[N:1];
   end

   always_comb begin
      start     = !loading_ff;
      has_room  = start || (len_ff < LenW'(MAX_PATTERN));
      pat_idx   = start ? '0 : len_ff[IdxW-1:0];
      lead_idx  = start ? '0 : len_ff;
      lead_base = start ? N'(1) : lead_ff;
      pat_we    = 1'b0;

      len_in     = len_ff;
      active_in  = active_ff;
      lead_in    = lead_ff;
      ovf_in     = ovf_ff;
      loading_in = loading_ff;
      out_push   = 1'b0;
      out_result.matched          = !ovf_ff && base[len_ff];
      out_result.pattern_overflow = ovf_ff;

      if (in_pop) begin
         case (in_item.op)
            glbm_pkg::OP_PATTERN_BYTE: begin
               loading_in = 1'b1;
               lead_in    = lead_base;
               if (start) begin
                  ovf_in    = 1'b0;
                  active_in = N'(1);
               end
               if (has_room) begin
                  pat_we = 1'b1;
                  len_in = LenW'(lead_idx + LenW'(1));
                  if (in_item.folded == glbm_pkg::StarByte && lead_base[lead_idx]) begin
                     lead_in[LenW'(lead_idx + LenW'(1))] = 1'b1;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
            glbm_pkg::OP_PATTERN_END: begin
               loading_in = 1'b0;
               active_in  = lead_ff;
            end
            glbm_pkg::OP_SUBJECT_BYTE: begin
               loading_in = 1'b0;
               active_in  = closed;
            end
            default: begin
               loading_in = 1'b0;
               active_in  = lead_ff;
               out_push   = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         active_ff  <= N'(1);
         lead_ff    <= N'(1);
         ovf_ff     <= 1'b0;
         loading_ff <= 1'b1;
      end else begin
         len_ff     <= len_in;
         active_ff  <= active_in;
         lead_ff    <= lead_in;
         ovf_ff     <= ovf_in;
         loading_ff <= loading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_ff[pat_idx] <= in_item.folded;
      end
   end

endmodule
